// ===== rtl/bgps_pkg.sv =====
// Shared constants, types and helpers of the grid point scatter unit.
`timescale 1ns / 1ps
package bgps_pkg;

	localparam int GRID_ROWS = 256;
	localparam int GRID_COLS = 256;
	localparam int ROW_W     = $clog2(GRID_ROWS);
	localparam int COL_W     = $clog2(GRID_COLS);
	localparam int IDX_W     = (ROW_W > COL_W) ? ROW_W : COL_W;
	localparam int LIM_W     = 11;
	localparam int DEPTH     = GRID_ROWS * GRID_COLS;
	localparam int ADDR_W    = $clog2(DEPTH);
	localparam int CM_W      = IDX_W + 17;
	localparam int T_W       = IDX_W + 19;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 16;

	localparam logic signed [15:0] X_MAX_RST     = 16'sd20480;
	localparam logic signed [15:0] Y_MAX_RST     = 16'sd10240;
	localparam logic        [15:0] RES_RST       = 16'd819;
	localparam logic        [15:0] CELL_SIZE_RST = 16'd80;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_READ   = 1'b1
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_X_MAX     = 2'd0,
		REG_Y_MAX     = 2'd1,
		REG_RES       = 2'd2,
		REG_CELL_SIZE = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic signed [15:0] x_max;
		logic signed [15:0] y_max;
		logic        [15:0] res;
		logic        [15:0] cell_size;
	} cfg_t;

	typedef struct packed {
		logic        [15:0] count;
		logic        [15:0] score;
		logic signed [15:0] off_x;
		logic signed [15:0] off_y;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DIFF,
		ST_MUL,
		ST_INDEX,
		ST_READ,
		ST_RMW
	} state_t;

	function automatic logic signed [15:0] sat_offset(
		input logic signed [15:0] p,
		input logic signed [15:0] d
	);
		logic signed [16:0] s;
		s = {p[15], p} - {d[15], d};
		if (s[16] != s[15])
			sat_offset = s[16] ? 16'sh8000 : 16'sh7FFF;
		else
			sat_offset = s[15:0];
	endfunction

endpackage

// ===== rtl/bgps_req_if.sv =====
// Input channel of the grid point scatter unit.
`timescale 1ns / 1ps
interface bgps_req_if;
	logic               valid;
	logic               ready;
	logic               operation;
	logic signed [15:0] point_x;
	logic signed [15:0] point_y;
	logic        [15:0] score;
	logic signed [15:0] reg_dx;
	logic signed [15:0] reg_dy;
	logic        [7:0]  read_row;
	logic        [7:0]  read_col;

	modport source (
		output valid, operation, point_x, point_y, score, reg_dx, reg_dy, read_row, read_col,
		input  ready
	);
	modport sink (
		input  valid, operation, point_x, point_y, score, reg_dx, reg_dy, read_row, read_col,
		output ready
	);
endinterface

// ===== rtl/bgps_rsp_if.sv =====
// Result channel of the grid point scatter unit.
`timescale 1ns / 1ps
interface bgps_rsp_if;
	logic               valid;
	logic               ready;
	logic               in_range;
	logic        [7:0]  cell_row;
	logic        [7:0]  cell_col;
	logic        [15:0] point_count;
	logic        [15:0] best_score;
	logic signed [15:0] offset_x;
	logic signed [15:0] offset_y;
	logic signed [16:0] center_x;
	logic signed [16:0] center_y;

	modport source (
		output valid, in_range, cell_row, cell_col, point_count, best_score,
		       offset_x, offset_y, center_x, center_y,
		input  ready
	);
	modport sink (
		input  valid, in_range, cell_row, cell_col, point_count, best_score,
		       offset_x, offset_y, center_x, center_y,
		output ready
	);
endinterface

// ===== rtl/bgps_ram.sv =====
// Single-port-write, registered-read RAM holding the grid cells.
`timescale 1ns / 1ps
module bgps_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 65536,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/bgps_cfg.sv =====
// Configuration register file of the grid point scatter unit.
`timescale 1ns / 1ps
module bgps_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          we,
	input  logic [bgps_pkg::CFG_IDX_W-1:0] idx,
	input  logic [bgps_pkg::CFG_W-1:0]     data,
	output bgps_pkg::cfg_t                cfg
);
	import bgps_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.x_max     <= X_MAX_RST;
			cfg_q.y_max     <= Y_MAX_RST;
			cfg_q.res       <= RES_RST;
			cfg_q.cell_size <= CELL_SIZE_RST;
		end else if (we) begin
			case (cfg_reg_t'(idx))
				REG_X_MAX:     cfg_q.x_max     <= data;
				REG_Y_MAX:     cfg_q.y_max     <= data;
				REG_RES:       cfg_q.res       <= data;
				REG_CELL_SIZE: cfg_q.cell_size <= data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/bgps_axis.sv =====
// Per-axis projection, range check and cell centre arithmetic.
`timescale 1ns / 1ps
module bgps_axis (
	input  logic                         clk,
	input  logic                         read_op,
	input  logic signed [15:0]           coord,
	input  logic signed [15:0]           bound,
	input  logic        [15:0]           res,
	input  logic        [15:0]           cell_size,
	input  logic        [7:0]            read_idx,
	input  logic [bgps_pkg::LIM_W-1:0]   limit,
	output logic [bgps_pkg::IDX_W-1:0]   idx,
	output logic                         ok,
	output logic signed [16:0]           centre
);
	import bgps_pkg::*;

	localparam logic signed [T_W-1:0] CEN_LO = T_W'(-65536);
	localparam logic signed [T_W-1:0] CEN_HI = T_W'(65535);

	logic signed [16:0]    diff_s1;
	logic signed [33:0]    prod_s2;
	logic [IDX_W-1:0]      idx_s3;
	logic                  ok_s3;
	logic [CM_W-1:0]       cmul_s4;
	logic [16:0]           grid_ix;
	logic                  ok_ins;
	logic signed [T_W-1:0] t;
	logic signed [T_W-1:0] h;

	assign grid_ix = prod_s2[32:16];
	assign ok_ins  = !prod_s2[33] && (grid_ix < {{(17-LIM_W){1'b0}}, limit});

	always_ff @(posedge clk) begin
		diff_s1 <= {bound[15], bound} - {coord[15], coord};
		prod_s2 <= diff_s1 * $signed({1'b0, res});
		idx_s3  <= read_op ? IDX_W'(read_idx) : grid_ix[IDX_W-1:0];
		ok_s3   <= read_op ? ({{(LIM_W-8){1'b0}}, read_idx} < limit) : ok_ins;
		cmul_s4 <= {idx_s3, 1'b1} * cell_size;
	end

	always_comb begin
		t = {{(T_W-17){bound[15]}}, bound, 1'b0} - {{(T_W-CM_W){1'b0}}, cmul_s4};
		h = t >>> 1;
		if (h < CEN_LO)
			centre = 17'sh10000;
		else if (h > CEN_HI)
			centre = 17'sh0FFFF;
		else
			centre = h[16:0];
	end

	assign idx = idx_s3;
	assign ok  = ok_s3;

endmodule

// ===== rtl/bev_grid_point_scatter_unit.sv =====
// Top level of the bird's-eye grid point scatter unit.
//
//   port       dir   handshake      carries
//   req        sink  valid/ready    insert point or cell read
//   rsp        src   valid/ready    cell contents and centre
//   cfg_*      in    write enable   grid bounds, resolution, cell size
//
// Items are taken one at a time, each through capture, subtract, multiply, index, RAM read,
// then read-modify-write of the cell RAM into the result register.
// A new item is taken while the previous result waits on rsp.
// After reset a clear pass writes all 65536 cells, one per cycle, before req opens.
// A stalled rsp holds the item in the modify step until the result register frees.
`timescale 1ns / 1ps
module bev_grid_point_scatter_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	bgps_req_if.sink                       req,
	bgps_rsp_if.source                     rsp,
	input  logic                           cfg_we,
	input  logic [bgps_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [bgps_pkg::CFG_W-1:0]     cfg_data
);
	import bgps_pkg::*;

	typedef logic [ENTRY_W-1:0] ram_data_t;

	cfg_t               cfg;
	state_t             state_q, state_d;
	logic [ADDR_W-1:0]  clr_q;
	logic [ADDR_W-1:0]  addr_q;

	logic               operation_q;
	logic signed [15:0] point_x_q, point_y_q, reg_dx_q, reg_dy_q;
	logic        [15:0] score_q;
	logic        [7:0]  read_row_q, read_col_q;

	logic               out_valid_q;
	logic               in_range_q;
	logic        [7:0]  cell_row_q, cell_col_q;
	logic        [15:0] point_count_q, best_score_q;
	logic signed [15:0] offset_x_q, offset_y_q;
	logic signed [16:0] center_x_q, center_y_q;

	logic [IDX_W-1:0]   idx_x, idx_y;
	logic               ok_x, ok_y, ok;
	logic signed [16:0] cen_x, cen_y;
	logic [ROW_W-1:0]   row;
	logic [COL_W-1:0]   col;
	logic [ADDR_W-1:0]  rd_addr;

	logic               accept, out_free, load_out, clr_last;
	logic               ram_we, ram_re;
	logic [ADDR_W-1:0]  ram_waddr;
	logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
	entry_t             old_e, upd_e, res_e;

	bgps_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.idx    (cfg_idx),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	bgps_axis u_axis_x (
		.clk       (clk),
		.read_op   (operation_q),
		.coord     (point_x_q),
		.bound     (cfg.x_max),
		.res       (cfg.res),
		.cell_size (cfg.cell_size),
		.read_idx  (read_row_q),
		.limit     (LIM_W'(GRID_ROWS)),
		.idx       (idx_x),
		.ok        (ok_x),
		.centre    (cen_x)
	);

	bgps_axis u_axis_y (
		.clk       (clk),
		.read_op   (operation_q),
		.coord     (point_y_q),
		.bound     (cfg.y_max),
		.res       (cfg.res),
		.cell_size (cfg.cell_size),
		.read_idx  (read_col_q),
		.limit     (LIM_W'(GRID_COLS)),
		.idx       (idx_y),
		.ok        (ok_y),
		.centre    (cen_y)
	);

	bgps_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	assign ok       = ok_x && ok_y;
	assign row      = idx_x[ROW_W-1:0];
	assign col      = idx_y[COL_W-1:0];
	assign rd_addr  = ADDR_W'(row) * ADDR_W'(GRID_COLS) + ADDR_W'(col);
	assign accept   = req.valid && req.ready;
	assign out_free = !out_valid_q || rsp.ready;
	assign clr_last = (clr_q == ADDR_W'(DEPTH - 1));

	always_comb begin
		old_e = entry_t'(ram_rdata);
		upd_e = old_e;
		if (old_e.count != 16'hFFFF)
			upd_e.count = old_e.count + 16'd1;
		if (score_q > old_e.score) begin
			upd_e.score = score_q;
			upd_e.off_x = sat_offset(point_x_q, reg_dx_q);
			upd_e.off_y = sat_offset(point_y_q, reg_dy_q);
		end
		res_e = (operation_q == OP_READ) ? old_e : upd_e;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: if (clr_last) state_d = ST_IDLE;
			ST_IDLE:  if (accept) state_d = ST_DIFF;
			ST_DIFF:  state_d = ST_MUL;
			ST_MUL:   state_d = ST_INDEX;
			ST_INDEX: state_d = ST_READ;
			ST_READ:  state_d = ST_RMW;
			ST_RMW:   if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req.ready = 1'b0;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_waddr = addr_q;
		ram_wdata = ram_data_t'(res_e);
		load_out  = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
			end
			ST_IDLE:  req.ready = 1'b1;
			ST_READ:  ram_re = 1'b1;
			ST_RMW: begin
				load_out = out_free;
				ram_we   = out_free && ok && (operation_q == OP_INSERT);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR)
				clr_q <= clr_q + ADDR_W'(1);
			if (load_out)
				out_valid_q <= 1'b1;
			else if (rsp.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			operation_q <= req.operation;
			point_x_q   <= req.point_x;
			point_y_q   <= req.point_y;
			score_q     <= req.score;
			reg_dx_q    <= req.reg_dx;
			reg_dy_q    <= req.reg_dy;
			read_row_q  <= req.read_row;
			read_col_q  <= req.read_col;
		end
		if (state_q == ST_READ)
			addr_q <= rd_addr;
		if (load_out) begin
			if (ok) begin
				in_range_q    <= 1'b1;
				cell_row_q    <= 8'(idx_x);
				cell_col_q    <= 8'(idx_y);
				point_count_q <= res_e.count;
				best_score_q  <= res_e.score;
				offset_x_q    <= res_e.off_x;
				offset_y_q    <= res_e.off_y;
				center_x_q    <= cen_x;
				center_y_q    <= cen_y;
			end else begin
				in_range_q    <= 1'b0;
				cell_row_q    <= '0;
				cell_col_q    <= '0;
				point_count_q <= '0;
				best_score_q  <= '0;
				offset_x_q    <= '0;
				offset_y_q    <= '0;
				center_x_q    <= '0;
				center_y_q    <= '0;
			end
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.in_range    = in_range_q;
	assign rsp.cell_row    = cell_row_q;
	assign rsp.cell_col    = cell_col_q;
	assign rsp.point_count = point_count_q;
	assign rsp.best_score  = best_score_q;
	assign rsp.offset_x    = offset_x_q;
	assign rsp.offset_y    = offset_y_q;
	assign rsp.center_x    = center_x_q;
	assign rsp.center_y    = center_y_q;

endmodule
